>>> hw/rtl/gtc_pkg.sv
// Shared types, constants and the signature lookup for the graphlet type classifier.
// No dependencies.
`timescale 1ns / 1ps

package gtc_pkg;

   localparam int NODES     = 5;
   localparam int PAIRS     = 10;
   localparam int DEG_W     = 3;
   localparam int COUNT_W   = 3;
   localparam int TYPE_W    = 5;
   localparam int SORT_CE   = 9;

   localparam logic [COUNT_W-1:0] COUNT_MIN = 3'd3;
   localparam logic [COUNT_W-1:0] COUNT_3   = 3'd3;
   localparam logic [COUNT_W-1:0] COUNT_4   = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_5   = 3'd5;

   localparam logic [DEG_W-1:0] DEG_1 = 3'd1;
   localparam logic [DEG_W-1:0] DEG_2 = 3'd2;
   localparam logic [DEG_W-1:0] DEG_3 = 3'd3;

   // node pair of each edge mask bit
   localparam logic [DEG_W-1:0] PAIR_I [PAIRS] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3};
   localparam logic [DEG_W-1:0] PAIR_J [PAIRS] = '{
      3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4};

   // five-input sorting network, applied in order
   localparam logic [DEG_W-1:0] CE_LO [SORT_CE] = '{
      3'd0, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1};
   localparam logic [DEG_W-1:0] CE_HI [SORT_CE] = '{
      3'd1, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2};

   typedef logic [NODES-1:0][DEG_W-1:0] deg_vec_type;

   typedef struct packed {
      logic [COUNT_W-1:0] node_count;
      logic [PAIRS-1:0]   edge_mask;
   } req_type;

   typedef struct packed {
      logic [TYPE_W-1:0] graphlet_type;
      logic              type_valid;
   } rsp_type;

   typedef struct packed {
      logic               count_ok;
      logic [COUNT_W-1:0] node_count;
      logic [PAIRS-1:0]   adj;
      deg_vec_type        deg;
   } deg_stage_type;

   typedef struct packed {
      logic               count_ok;
      logic [COUNT_W-1:0] node_count;
      deg_vec_type        sorted;
      logic               split_a;
      logic               split_b;
   } sort_stage_type;

   function automatic rsp_type sig_lookup(
      input logic [COUNT_W-1:0] n,
      input deg_vec_type        s,
      input logic               split_a,
      input logic               split_b
   );
      rsp_type r;
      logic [3*DEG_W-1:0] s3;
      logic [4*DEG_W-1:0] s4;
      logic [5*DEG_W-1:0] s5;
      r  = '0;
      s3 = {s[2], s[3], s[4]};
      s4 = {s[1], s[2], s[3], s[4]};
      s5 = {s[0], s[1], s[2], s[3], s[4]};
      r.type_valid = 1'b1;
      case (n)
         COUNT_3: begin
            case (s3)
               {3'd1, 3'd1, 3'd2}: r.graphlet_type = 5'd0;
               {3'd2, 3'd2, 3'd2}: r.graphlet_type = 5'd1;
               default:            r.type_valid = 1'b0;
            endcase
         end
         COUNT_4: begin
            case (s4)
               {3'd1, 3'd1, 3'd2, 3'd2}: r.graphlet_type = 5'd2;
               {3'd1, 3'd1, 3'd1, 3'd3}: r.graphlet_type = 5'd3;
               {3'd2, 3'd2, 3'd2, 3'd2}: r.graphlet_type = 5'd4;
               {3'd1, 3'd2, 3'd2, 3'd3}: r.graphlet_type = 5'd5;
               {3'd2, 3'd2, 3'd3, 3'd3}: r.graphlet_type = 5'd6;
               {3'd3, 3'd3, 3'd3, 3'd3}: r.graphlet_type = 5'd7;
               default:                  r.type_valid = 1'b0;
            endcase
         end
         COUNT_5: begin
            case (s5)
               {3'd1, 3'd1, 3'd2, 3'd2, 3'd2}: r.graphlet_type = 5'd8;
               {3'd1, 3'd1, 3'd1, 3'd2, 3'd3}: r.graphlet_type = 5'd9;
               {3'd1, 3'd1, 3'd1, 3'd1, 3'd4}: r.graphlet_type = 5'd10;
               {3'd1, 3'd1, 3'd2, 3'd3, 3'd3}: r.graphlet_type = 5'd11;
               {3'd1, 3'd2, 3'd2, 3'd2, 3'd3}:
                  r.graphlet_type = split_a ? 5'd12 : 5'd15;
               {3'd1, 3'd1, 3'd2, 3'd2, 3'd4}: r.graphlet_type = 5'd13;
               {3'd2, 3'd2, 3'd2, 3'd2, 3'd2}: r.graphlet_type = 5'd14;
               {3'd1, 3'd2, 3'd2, 3'd3, 3'd4}: r.graphlet_type = 5'd16;
               {3'd2, 3'd2, 3'd2, 3'd2, 3'd4}: r.graphlet_type = 5'd17;
               {3'd1, 3'd2, 3'd3, 3'd3, 3'd3}: r.graphlet_type = 5'd18;
               {3'd2, 3'd2, 3'd2, 3'd3, 3'd3}:
                  r.graphlet_type = split_b ? 5'd20 : 5'd19;
               {3'd2, 3'd2, 3'd2, 3'd4, 3'd4}: r.graphlet_type = 5'd21;
               {3'd1, 3'd3, 3'd3, 3'd3, 3'd4}: r.graphlet_type = 5'd22;
               {3'd2, 3'd2, 3'd3, 3'd3, 3'd4}: r.graphlet_type = 5'd23;
               {3'd2, 3'd3, 3'd3, 3'd3, 3'd3}: r.graphlet_type = 5'd24;
               {3'd2, 3'd3, 3'd3, 3'd4, 3'd4}: r.graphlet_type = 5'd25;
               {3'd3, 3'd3, 3'd3, 3'd3, 3'd4}: r.graphlet_type = 5'd26;
               {3'd3, 3'd3, 3'd4, 3'd4, 3'd4}: r.graphlet_type = 5'd27;
               {3'd4, 3'd4, 3'd4, 3'd4, 3'd4}: r.graphlet_type = 5'd28;
               default:                        r.type_valid = 1'b0;
            endcase
         end
         default: r.type_valid = 1'b0;
      endcase
      if (!r.type_valid) begin
         r.graphlet_type = '0;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/gtc_degree.sv
// Stage 1: masks edges beyond the node count and computes node degrees.
// Depends on gtc_pkg.
`timescale 1ns / 1ps

module gtc_degree
   import gtc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_type       in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output deg_stage_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   deg_stage_type data_ff;
   deg_stage_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in            = '0;
      data_in.node_count = in_data.node_count;
      data_in.count_ok   = (in_data.node_count >= COUNT_MIN)
                           && (in_data.node_count <= COUNT_5);
      for (int p = 0; p < PAIRS; p++) begin
         data_in.adj[p] = in_data.edge_mask[p] && (PAIR_J[p] < in_data.node_count);
         data_in.deg[PAIR_I[p]] = data_in.deg[PAIR_I[p]] + DEG_W'(data_in.adj[p]);
         data_in.deg[PAIR_J[p]] = data_in.deg[PAIR_J[p]] + DEG_W'(data_in.adj[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/gtc_sort.sv
// Stage 2: sorts the degrees ascending and evaluates the two neighbour tests.
// Depends on gtc_pkg.
`timescale 1ns / 1ps

module gtc_sort
   import gtc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  deg_stage_type  in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output sort_stage_type out_data
);

   logic           valid_ff;
   logic           valid_in;
   sort_stage_type data_ff;
   sort_stage_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic [DEG_W-1:0] lo;
      logic [DEG_W-1:0] hi;
      logic [DEG_W-1:0] di;
      logic [DEG_W-1:0] dj;
      data_in            = '0;
      data_in.count_ok   = in_data.count_ok;
      data_in.node_count = in_data.node_count;
      data_in.sorted     = in_data.deg;
      for (int c = 0; c < SORT_CE; c++) begin
         lo = data_in.sorted[CE_LO[c]];
         hi = data_in.sorted[CE_HI[c]];
         if (lo > hi) begin
            data_in.sorted[CE_LO[c]] = hi;
            data_in.sorted[CE_HI[c]] = lo;
         end
      end
      for (int p = 0; p < PAIRS; p++) begin
         di = in_data.deg[PAIR_I[p]];
         dj = in_data.deg[PAIR_J[p]];
         if (in_data.adj[p]) begin
            if ((di == DEG_1 && dj == DEG_2) || (di == DEG_2 && dj == DEG_1)) begin
               data_in.split_a = 1'b1;
            end
            if (di == DEG_3 && dj == DEG_3) begin
               data_in.split_b = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/gtc_match.sv
// Stage 3: matches the sorted signature against the graphlet table; output register.
// Depends on gtc_pkg.
`timescale 1ns / 1ps

module gtc_match
   import gtc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  sort_stage_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output rsp_type        out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      if (in_data.count_ok) begin
         data_in = sig_lookup(in_data.node_count, in_data.sorted,
                              in_data.split_a, in_data.split_b);
      end else begin
         data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/graphlet_type_classifier_core.sv
// Graphlet type classifier: top level, three-stage pipeline.
// Depends on gtc_pkg, gtc_degree, gtc_sort, gtc_match.
//
// Usage:
//   req_ channel carries one graphlet (node_count 3..5, upper-triangle edge_mask).
//   rsp_ channel returns graphlet_type (0..28) and type_valid, one result per
//   request, in request order. Unmatched signatures and bad counts give
//   type_valid 0 with type 0.
//   Path: each request passes the degree, sort and match stage registers, in
//   that order, before it reaches rsp_valid.
//   Throughput: one transfer per cycle while rsp_ready stays high; every stage holds one item and takes a
//   new one whenever its own register is empty or is being drained that cycle.
//   Stall: when rsp_ready is low the result holds in the output register and
//   the stages behind it fill up; req_ready drops once all three are full.
//   Reset: synchronous, clears all stage valid bits; the pipeline is empty and
//   req_ready is high in the first cycle after reset.
`timescale 1ns / 1ps

module graphlet_type_classifier_core
   import gtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic           s1_valid;
   logic           s1_ready;
   deg_stage_type  s1_data;
   logic           s2_valid;
   logic           s2_ready;
   sort_stage_type s2_data;

   gtc_degree u_degree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   gtc_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   gtc_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

>>> test/tb_graphlet_type_classifier_core.sv
// Testbench for graphlet_type_classifier_core: directed and random graphlets checked against
// a local degree-signature classifier, with sender gaps and receiver stalls.
// Depends on gtc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_graphlet_type_classifier_core;
   import gtc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;
   localparam int HOLD_CYCLES    = 60;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_kind_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type        types_due [$];
   int             fail_count  = 0;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   int             gap_max     = 0;
   int             hold_left   = 0;
   stall_kind_type stall_mode  = STALL_NONE;
   logic [7:0]     stall_pat   = 8'hFF;
   logic [2:0]     pat_pos     = '0;

   graphlet_type_classifier_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // degree signature lookup, with the two ambiguous five-node signatures split
   function automatic rsp_type predict_graphlet_type(input req_type g);
      int unsigned deg [5];
      int unsigned sorted [5];
      bit          adj [5][5];
      int unsigned n, bit_idx, key, v, k;
      bit          tail_on_path, hubs_adjacent;
      rsp_type     r;
      r = '0;
      n = {29'd0, g.node_count};
      bit_idx = 0;
      tail_on_path = 1'b0;
      hubs_adjacent = 1'b0;
      foreach (deg[i]) begin
         deg[i] = 0;
         sorted[i] = 0;
      end
      foreach (adj[i, j]) adj[i][j] = 1'b0;
      if (n < COUNT_MIN || n > COUNT_5) begin
         return r;
      end
      for (int i = 0; i < NODES; i++) begin
         for (int j = i + 1; j < NODES; j++) begin
            if (i < n && j < n && g.edge_mask[bit_idx]) begin
               adj[i][j] = 1'b1;
               adj[j][i] = 1'b1;
               deg[i]++;
               deg[j]++;
            end
            bit_idx++;
         end
      end
      for (int i = 0; i < n; i++) begin
         v = deg[i];
         k = i;
         while (k > 0 && sorted[k-1] > v) begin
            sorted[k] = sorted[k-1];
            k--;
         end
         sorted[k] = v;
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (adj[i][j] && deg[i] == 1 && deg[j] == 2) tail_on_path = 1'b1;
            if (adj[i][j] && deg[i] == 3 && deg[j] == 3) hubs_adjacent = 1'b1;
         end
      end
      key = n;
      for (int i = 0; i < n; i++) key = key * 10 + sorted[i];
      r.type_valid = 1'b1;
      case (key)
         3112:    r.graphlet_type = 5'd0;
         3222:    r.graphlet_type = 5'd1;
         41122:   r.graphlet_type = 5'd2;
         41113:   r.graphlet_type = 5'd3;
         42222:   r.graphlet_type = 5'd4;
         41223:   r.graphlet_type = 5'd5;
         42233:   r.graphlet_type = 5'd6;
         43333:   r.graphlet_type = 5'd7;
         511222:  r.graphlet_type = 5'd8;
         511123:  r.graphlet_type = 5'd9;
         511114:  r.graphlet_type = 5'd10;
         511233:  r.graphlet_type = 5'd11;
         512223:  r.graphlet_type = tail_on_path ? 5'd12 : 5'd15;
         511224:  r.graphlet_type = 5'd13;
         522222:  r.graphlet_type = 5'd14;
         512234:  r.graphlet_type = 5'd16;
         522224:  r.graphlet_type = 5'd17;
         512333:  r.graphlet_type = 5'd18;
         522233:  r.graphlet_type = hubs_adjacent ? 5'd20 : 5'd19;
         522244:  r.graphlet_type = 5'd21;
         513334:  r.graphlet_type = 5'd22;
         522334:  r.graphlet_type = 5'd23;
         523333:  r.graphlet_type = 5'd24;
         523344:  r.graphlet_type = 5'd25;
         533334:  r.graphlet_type = 5'd26;
         533444:  r.graphlet_type = 5'd27;
         544444:  r.graphlet_type = 5'd28;
         default: r.type_valid = 1'b0;
      endcase
      if (!r.type_valid) r.graphlet_type = '0;
      return r;
   endfunction

   function automatic req_type random_graphlet();
      req_type     g;
      int unsigned v;
      if ($urandom_range(99, 0) < 8) begin
         v = $urandom_range(4, 0);
         g.node_count = COUNT_W'((v < 3) ? v : v + 3);
      end else begin
         g.node_count = COUNT_W'($urandom_range(5, 3));
      end
      g.edge_mask = PAIRS'($urandom_range(1023, 0));
      return g;
   endfunction

   task automatic send_graphlet(input logic [COUNT_W-1:0] n, input logic [PAIRS-1:0] mask);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(gap_max, 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{node_count: n, edge_mask: mask};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic stop_and_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (types_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      stall_mode = STALL_NONE;
      gap_max = 0;
      send_graphlet(3'd3, 10'h000);
      send_graphlet(3'd3, 10'h003);
      send_graphlet(3'd3, 10'h013);
      send_graphlet(3'd3, 10'h3EF);
      send_graphlet(3'd3, 10'h3FF);
      send_graphlet(3'd4, 10'h3FF);
      send_graphlet(3'd4, 10'h000);
      send_graphlet(3'd4, 10'h3A5);
      send_graphlet(3'd5, 10'h3FF);
      send_graphlet(3'd5, 10'h000);
      send_graphlet(3'd5, 10'd659);
      send_graphlet(3'd5, 10'd157);
      send_graphlet(3'd5, 10'd667);
      send_graphlet(3'd5, 10'd126);
      send_graphlet(3'd5, 10'h00F);
      send_graphlet(3'd0, 10'h3FF);
      send_graphlet(3'd1, 10'h3FF);
      send_graphlet(3'd2, 10'h3FF);
      send_graphlet(3'd6, 10'h3FF);
      send_graphlet(3'd7, 10'h3FF);
      send_graphlet(3'd7, 10'h000);
      stop_and_drain();
   endtask

   task automatic test_random_traffic();
      req_type g;
      for (int phase = 0; phase < 6; phase++) begin
         stall_mode = stall_kind_type'(phase % 3);
         gap_max    = (phase % 2) ? 10 : ((phase < 3) ? 3 : 0);
         stall_pat  = 8'($urandom_range(254, 1));
         for (int i = 0; i < 260; i++) begin
            g = random_graphlet();
            send_graphlet(g.node_count, g.edge_mask);
         end
         stop_and_drain();
      end
   endtask

   task automatic test_backpressure();
      req_type g;
      stall_mode = STALL_NONE;
      gap_max = 0;
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) begin
         g = random_graphlet();
         send_graphlet(g.node_count, g.edge_mask);
      end
      stop_and_drain();
   endtask

   task automatic test_drain_pause();
      req_type g;
      stall_mode = STALL_RANDOM;
      gap_max = 2;
      for (int round = 0; round < 2; round++) begin
         for (int i = 0; i < 20; i++) begin
            g = random_graphlet();
            send_graphlet(g.node_count, g.edge_mask);
         end
         stop_and_drain();
      end
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         case (stall_mode)
            STALL_NONE:    rsp_ready <= 1'b1;
            STALL_RANDOM:  rsp_ready <= 1'($urandom_range(1, 0));
            STALL_PATTERN: rsp_ready <= stall_pat[pat_pos];
            default:       rsp_ready <= 1'b1;
         endcase
      end
      pat_pos <= pat_pos + 1'b1;
   end

   // request transfers load the expected results
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         types_due.insert(types_due.size(), predict_graphlet_type(req_data));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (types_due.size() == 0) begin
            $error("unexpected result transfer: graphlet_type %0d type_valid %0d",
                   rsp_data.graphlet_type, rsp_data.type_valid);
            fail_count++;
         end else begin
            want = types_due[0];
            types_due.delete(0);
            if (rsp_data.graphlet_type !== want.graphlet_type) begin
               $error("graphlet_type mismatch: expected %0d, actual %0d",
                      want.graphlet_type, rsp_data.graphlet_type);
               fail_count++;
            end
            if (rsp_data.type_valid !== want.type_valid) begin
               $error("type_valid mismatch: expected %0d, actual %0d",
                      want.type_valid, rsp_data.type_valid);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_traffic();
      test_drain_pause();
      if (types_due.size() != 0) begin
         $error("%0d expected results never arrived", types_due.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
